/* hdl/psp_pkg.sv */
// Shared constants, types and opcodes of the polyphonic sample player.
`timescale 1ns / 1ps
package psp_pkg;
    localparam int VOICES      = 8;
    localparam int SOUNDS      = 8;
    localparam int MAX_SAMPLES = 16384;
    localparam int VW   = $clog2(VOICES);
    localparam int SW   = 3;
    localparam int WW   = $clog2(MAX_SAMPLES);
    localparam int AW   = SW + WW;
    localparam int LW   = WW + 1;
    localparam int PW   = 31;
    localparam int MIXW = 23;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_TRIG   = 3'd1,
        OP_LOOP   = 3'd2,
        OP_STOP   = 3'd3,
        OP_ALL    = 3'd4,
        OP_FRAME  = 3'd5
    } op_t;

    localparam logic signed [MIXW-1:0] MIX_MAX = 23'sh3FFFFF;
    localparam logic signed [MIXW-1:0] MIX_MIN = 23'sh400000;

    function automatic logic [LW-1:0] clamp_loop(input logic [14:0] req,
                                                 input logic [LW-1:0] len);
        logic [LW-1:0] r;
        begin
            r = LW'(req);
            if (r == '0)
                clamp_loop = '0;
            else
                clamp_loop = (r < len) ? r : len;
        end
    endfunction
endpackage

/* hdl/psp_if.sv */
// Valid/ready channel interfaces for the sample player input and result items.
`timescale 1ns / 1ps
interface psp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [2:0]  sound_id;
    logic [13:0] word_index;
    logic signed [15:0] sample_value;
    logic        last_word;
    logic [15:0] gain;
    logic [23:0] pitch_ratio;
    logic [14:0] loop_end;
    modport source (output valid, opcode, sound_id, word_index, sample_value, last_word,
                    gain, pitch_ratio, loop_end, input ready);
    modport sink (input valid, opcode, sound_id, word_index, sample_value, last_word,
                  gain, pitch_ratio, loop_end, output ready);
endinterface

interface psp_out_if;
    logic        valid;
    logic        ready;
    logic signed [22:0] left_out;
    logic signed [22:0] right_out;
    logic [3:0]  active_voices;
    logic        sound_playing;
    modport source (output valid, left_out, right_out, active_voices, sound_playing,
                    input ready);
    modport sink (input valid, left_out, right_out, active_voices, sound_playing,
                  output ready);
endinterface

/* hdl/psp_sample_ram.sv */
// Sample word store: one write port, one registered read port.
`timescale 1ns / 1ps
module psp_sample_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [psp_pkg::AW-1:0]    waddr,
    input  logic signed [15:0]        wdata,
    input  logic [psp_pkg::AW-1:0]    raddr,
    output logic signed [15:0]        rdata
);
    logic signed [15:0] mem [0:(1 << psp_pkg::AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* hdl/polyphonic_sample_player_unit.sv */
// Top level: sequencer that walks the voices with one shared datapath.
// A frame walks each voice through the check, read, multiply and accumulate states; an idle
// or finished voice goes from check straight to accumulate.
// Throughput: one item at a time; a new item is not accepted until the result is taken.
// Reset: asynchronous active low; clears voices and sound lengths, not the sample words.
`timescale 1ns / 1ps
module polyphonic_sample_player_unit (
    input  logic      clk,
    input  logic      rst_n,
    psp_in_if.sink    in_ch,
    psp_out_if.source out_ch
);
    localparam int VW = psp_pkg::VW;
    localparam int LW = psp_pkg::LW;
    localparam int PW = psp_pkg::PW;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_PICK, S_FCHK, S_FRD, S_FMUL, S_FACC, S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0]  op_reg;
    logic [2:0]  snd_reg;
    logic [13:0] widx_reg;
    logic signed [15:0] sval_reg;
    logic        last_reg;
    logic [15:0] g_reg;
    logic [23:0] pitch_reg;
    logic [14:0] lend_reg;
    logic [VW:0] vi_reg;
    logic [VW-1:0] best_reg;
    logic        free_found_reg;
    logic [VW-1:0] free_reg;
    logic signed [40:0] sum_reg;
    logic signed [31:0] prod_reg;
    logic        add_reg;

    logic [LW-1:0] snd_len_reg [psp_pkg::SOUNDS];
    logic          v_act_reg  [psp_pkg::VOICES];
    logic [2:0]    v_snd_reg  [psp_pkg::VOICES];
    logic [PW-1:0] v_pos_reg  [psp_pkg::VOICES];
    logic [LW-1:0] v_len_reg  [psp_pkg::VOICES];
    logic [LW-1:0] v_lend_reg [psp_pkg::VOICES];
    logic [15:0]   v_gain_reg [psp_pkg::VOICES];
    logic [23:0]   v_pitch_reg[psp_pkg::VOICES];

    logic signed [22:0] mix_reg;
    logic [3:0] cnt_reg;
    logic       play_reg;

    logic [VW-1:0] vi;
    logic [LW-1:0] vend;
    logic signed [15:0] rdata;
    logic ram_we;

    assign vi = vi_reg[VW-1:0];
    assign vend = (v_lend_reg[vi] != '0) ? v_lend_reg[vi] : v_len_reg[vi];
    assign ram_we = (state_reg == S_SCAN) && (op_reg == psp_pkg::OP_LOAD);

    psp_sample_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({snd_reg, widx_reg}),
        .wdata (sval_reg),
        .raddr ({v_snd_reg[vi], v_pos_reg[vi][16+psp_pkg::WW-1:16]}),
        .rdata (rdata)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.left_out = mix_reg;
    assign out_ch.right_out = mix_reg;
    assign out_ch.active_voices = cnt_reg;
    assign out_ch.sound_playing = play_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vi_reg <= '0;
            for (int i = 0; i < psp_pkg::SOUNDS; i++)
                snd_len_reg[i] <= '0;
            for (int i = 0; i < psp_pkg::VOICES; i++)
            begin
                v_act_reg[i] <= 1'b0;
                v_snd_reg[i] <= '0;
                v_pos_reg[i] <= '0;
                v_len_reg[i] <= '0;
                v_lend_reg[i] <= '0;
                v_gain_reg[i] <= '0;
                v_pitch_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        op_reg <= in_ch.opcode;
                        snd_reg <= in_ch.sound_id;
                        widx_reg <= in_ch.word_index;
                        sval_reg <= in_ch.sample_value;
                        last_reg <= in_ch.last_word;
                        g_reg <= in_ch.gain;
                        pitch_reg <= in_ch.pitch_ratio;
                        lend_reg <= in_ch.loop_end;
                        vi_reg <= '0;
                        best_reg <= '0;
                        free_found_reg <= 1'b0;
                        sum_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    case (op_reg)
                        psp_pkg::OP_LOAD:
                        begin
                            if (last_reg)
                                snd_len_reg[snd_reg] <= LW'(widx_reg) + LW'(1);
                            state_reg <= S_DONE;
                        end
                        psp_pkg::OP_ALL:
                        begin
                            for (int i = 0; i < psp_pkg::VOICES; i++)
                                v_act_reg[i] <= 1'b0;
                            state_reg <= S_DONE;
                        end
                        psp_pkg::OP_FRAME: state_reg <= S_FCHK;
                        psp_pkg::OP_TRIG:
                        begin
                            if (snd_len_reg[snd_reg] == '0)
                                state_reg <= S_DONE;
                            else
                            begin
                                if (!v_act_reg[vi] && !free_found_reg)
                                begin
                                    free_found_reg <= 1'b1;
                                    free_reg <= vi;
                                end
                                if (v_gain_reg[vi] < v_gain_reg[best_reg])
                                    best_reg <= vi;
                                vi_reg <= vi_reg + 1'b1;
                                if (vi_reg == (VW+1)'(psp_pkg::VOICES - 1))
                                    state_reg <= S_PICK;
                            end
                        end
                        psp_pkg::OP_LOOP, psp_pkg::OP_STOP:
                        begin
                            if (v_snd_reg[vi] == snd_reg)
                            begin
                                if (op_reg == psp_pkg::OP_STOP)
                                    v_act_reg[vi] <= 1'b0;
                                else if (v_act_reg[vi])
                                    v_lend_reg[vi] <= psp_pkg::clamp_loop(lend_reg,
                                                                          v_len_reg[vi]);
                            end
                            vi_reg <= vi_reg + 1'b1;
                            if (vi_reg == (VW+1)'(psp_pkg::VOICES - 1))
                                state_reg <= S_DONE;
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_PICK:
                begin
                    begin : pick
                        logic [VW-1:0] v;
                        v = free_found_reg ? free_reg : best_reg;
                        v_snd_reg[v] <= snd_reg;
                        v_len_reg[v] <= snd_len_reg[snd_reg];
                        v_pos_reg[v] <= '0;
                        v_lend_reg[v] <= psp_pkg::clamp_loop(lend_reg, snd_len_reg[snd_reg]);
                        v_gain_reg[v] <= g_reg;
                        v_pitch_reg[v] <= pitch_reg;
                        v_act_reg[v] <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_FCHK:
                begin
                    add_reg <= 1'b0;
                    if (!v_act_reg[vi])
                        state_reg <= S_FACC;
                    else if (LW'(v_pos_reg[vi][PW-1:16]) >= vend)
                    begin
                        if (v_lend_reg[vi] != '0)
                        begin
                            v_pos_reg[vi] <= '0;
                            state_reg <= S_FRD;
                        end
                        else
                        begin
                            v_act_reg[vi] <= 1'b0;
                            state_reg <= S_FACC;
                        end
                    end
                    else
                        state_reg <= S_FRD;
                end
                S_FRD: state_reg <= S_FMUL;
                S_FMUL:
                begin
                    prod_reg <= rdata * $signed({1'b0, v_gain_reg[vi]});
                    add_reg <= 1'b1;
                    v_pos_reg[vi] <= v_pos_reg[vi] + PW'(v_pitch_reg[vi]);
                    state_reg <= S_FACC;
                end
                S_FACC:
                begin
                    if (add_reg)
                        sum_reg <= sum_reg + 41'(prod_reg >>> 12);
                    vi_reg <= vi_reg + 1'b1;
                    if (vi_reg == (VW+1)'(psp_pkg::VOICES - 1))
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_FCHK;
                end
                S_DONE:
                begin
                    begin : fin
                        logic [VW:0] c;
                        logic p;
                        c = '0;
                        p = 1'b0;
                        for (int i = 0; i < psp_pkg::VOICES; i++)
                            if (v_act_reg[i])
                            begin
                                c = c + 1'b1;
                                if (v_snd_reg[i] == snd_reg)
                                    p = 1'b1;
                            end
                        cnt_reg <= (c > 15) ? 4'd15 : 4'(c);
                        play_reg <= p;
                    end
                    if (op_reg != psp_pkg::OP_FRAME)
                        mix_reg <= '0;
                    else if (sum_reg > 41'(psp_pkg::MIX_MAX))
                        mix_reg <= psp_pkg::MIX_MAX;
                    else if (sum_reg < 41'(psp_pkg::MIX_MIN))
                        mix_reg <= psp_pkg::MIX_MIN;
                    else
                        mix_reg <= sum_reg[22:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/psp_checker.sv */
// Port-level checker for the sample player, bound to the top level.
`timescale 1ns / 1ps
module psp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic signed [22:0] left_out,
    input logic signed [22:0] right_out,
    input logic [3:0]  active_voices
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input ready while result pending");
    a_lr_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_out == right_out)) else $error("channels differ");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active_voices <= 4'd8)) else $error("voice count too large");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(left_out)))
        else $error("result dropped");
endmodule

bind polyphonic_sample_player_unit psp_checker u_psp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .left_out      (out_ch.left_out),
    .right_out     (out_ch.right_out),
    .active_voices (out_ch.active_voices)
);

/* dv/tb.sv */
// Self-checking testbench for the polyphonic sample player unit.
`timescale 1ns / 1ps
module tb;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_RANDOM = 1100;

    typedef struct {
        logic [2:0]         opcode;
        logic [2:0]         sound_id;
        logic [13:0]        word_index;
        logic signed [15:0] sample_value;
        logic               last_word;
        logic [15:0]        gain;
        logic [23:0]        pitch_ratio;
        logic [14:0]        loop_end;
    } cmd_t;

    typedef struct {
        logic signed [22:0] mix;
        logic [3:0]         active_voices;
        logic               sound_playing;
    } mix_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    psp_in_if  in_ch ();
    psp_out_if out_ch ();

    polyphonic_sample_player_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #4 clk = ~clk;

    // Shadow copy of the player state.
    logic signed [15:0] smp_mem [0:psp_pkg::SOUNDS*psp_pkg::MAX_SAMPLES-1];
    bit                 smp_written [0:psp_pkg::SOUNDS*psp_pkg::MAX_SAMPLES-1];
    int unsigned        snd_prefix [psp_pkg::SOUNDS];
    logic [14:0]        snd_len [psp_pkg::SOUNDS];
    bit                 vc_active [psp_pkg::VOICES];
    logic [2:0]         vc_sound [psp_pkg::VOICES];
    logic [31:0]        vc_pos [psp_pkg::VOICES];
    logic [14:0]        vc_len [psp_pkg::VOICES];
    logic [14:0]        vc_loop [psp_pkg::VOICES];
    logic [15:0]        vc_gain [psp_pkg::VOICES];
    logic [23:0]        vc_pitch [psp_pkg::VOICES];

    mix_result_t pending_mix [$];
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int errors = 0;
    int n_items = 0;
    int n_frames = 0;
    int n_results = 0;
    int unsigned cycle_cnt = 0;

    function automatic logic [14:0] clip_loop(logic [14:0] req, logic [14:0] len);
        if (req == '0)
            return '0;
        return (req < len) ? req : len;
    endfunction

    function automatic mix_result_t play_cmd(cmd_t c);
        mix_result_t r;
        longint sum;
        logic [14:0] stop_at;
        int v;
        int slot;
        sum = 0;
        case (c.opcode)
            psp_pkg::OP_LOAD:
            begin
                smp_mem[{c.sound_id, c.word_index}] = c.sample_value;
                smp_written[{c.sound_id, c.word_index}] = 1'b1;
                while (snd_prefix[c.sound_id] < psp_pkg::MAX_SAMPLES &&
                       smp_written[c.sound_id * psp_pkg::MAX_SAMPLES +
                                   snd_prefix[c.sound_id]])
                    snd_prefix[c.sound_id]++;
                if (c.last_word)
                    snd_len[c.sound_id] = 15'(c.word_index) + 15'd1;
            end
            psp_pkg::OP_TRIG:
            begin
                if (snd_len[c.sound_id] != '0)
                begin
                    slot = -1;
                    for (v = 0; v < psp_pkg::VOICES; v++)
                        if (slot < 0 && !vc_active[v])
                            slot = v;
                    if (slot < 0)
                    begin
                        // Steal the quietest voice; ties favor the lowest index.
                        slot = 0;
                        for (v = 1; v < psp_pkg::VOICES; v++)
                            if (vc_gain[v] < vc_gain[slot])
                                slot = v;
                    end
                    vc_sound[slot] = c.sound_id;
                    vc_len[slot] = snd_len[c.sound_id];
                    vc_pos[slot] = '0;
                    vc_loop[slot] = clip_loop(c.loop_end, snd_len[c.sound_id]);
                    vc_gain[slot] = c.gain;
                    vc_pitch[slot] = c.pitch_ratio;
                    vc_active[slot] = 1'b1;
                end
            end
            psp_pkg::OP_LOOP:
            begin
                for (v = 0; v < psp_pkg::VOICES; v++)
                    if (vc_active[v] && vc_sound[v] == c.sound_id)
                        vc_loop[v] = clip_loop(c.loop_end, vc_len[v]);
            end
            psp_pkg::OP_STOP:
            begin
                for (v = 0; v < psp_pkg::VOICES; v++)
                    if (vc_sound[v] == c.sound_id)
                        vc_active[v] = 1'b0;
            end
            psp_pkg::OP_ALL:
            begin
                for (v = 0; v < psp_pkg::VOICES; v++)
                    vc_active[v] = 1'b0;
            end
            psp_pkg::OP_FRAME:
            begin
                for (v = 0; v < psp_pkg::VOICES; v++)
                begin
                    if (!vc_active[v])
                        continue;
                    stop_at = (vc_loop[v] != '0) ? vc_loop[v] : vc_len[v];
                    if (vc_pos[v][31:16] >= stop_at)
                    begin
                        if (vc_loop[v] != '0)
                        begin
                            vc_pos[v] = '0;
                        end
                        else
                        begin
                            vc_active[v] = 1'b0;
                            continue;
                        end
                    end
                    sum += (longint'(smp_mem[{vc_sound[v], vc_pos[v][29:16]}]) *
                            longint'(vc_gain[v])) >>> 12;
                    vc_pos[v] = vc_pos[v] + vc_pitch[v];
                end
                if (sum > longint'(psp_pkg::MIX_MAX))
                    sum = psp_pkg::MIX_MAX;
                if (sum < longint'(psp_pkg::MIX_MIN))
                    sum = psp_pkg::MIX_MIN;
            end
            default: ;
        endcase
        r.mix = 23'(sum);
        r.active_voices = '0;
        r.sound_playing = 1'b0;
        for (v = 0; v < psp_pkg::VOICES; v++)
        begin
            if (vc_active[v])
            begin
                r.active_voices++;
                if (vc_sound[v] == c.sound_id)
                    r.sound_playing = 1'b1;
            end
        end
        return r;
    endfunction

    // Valid stays high across back-to-back transactions; it only drops for a gap.
    task automatic send_cmd(cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= c.opcode;
        in_ch.sound_id     <= c.sound_id;
        in_ch.word_index   <= c.word_index;
        in_ch.sample_value <= c.sample_value;
        in_ch.last_word    <= c.last_word;
        in_ch.gain         <= c.gain;
        in_ch.pitch_ratio  <= c.pitch_ratio;
        in_ch.loop_end     <= c.loop_end;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_mix.push_back(play_cmd(c));
        n_items++;
        if (c.opcode == psp_pkg::OP_FRAME)
            n_frames++;
    endtask

    task automatic send_op(logic [2:0] op, logic [2:0] snd, logic [13:0] idx,
                           logic signed [15:0] val, logic last, logic [15:0] g,
                           logic [23:0] p, logic [14:0] le);
        cmd_t c;
        c.opcode = op;
        c.sound_id = snd;
        c.word_index = idx;
        c.sample_value = val;
        c.last_word = last;
        c.gain = g;
        c.pitch_ratio = p;
        c.loop_end = le;
        send_cmd(c);
    endtask

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        mix_result_t e;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL polyphonic_sample_player_unit");
            $finish;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_results++;
            if (pending_mix.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                e = pending_mix.pop_front();
                if (out_ch.left_out !== e.mix)
                begin
                    $error("left_out expected %0d actual %0d", e.mix, out_ch.left_out);
                    errors++;
                end
                if (out_ch.right_out !== e.mix)
                begin
                    $error("right_out expected %0d actual %0d", e.mix, out_ch.right_out);
                    errors++;
                end
                if (out_ch.active_voices !== e.active_voices)
                begin
                    $error("active_voices expected %0d actual %0d",
                           e.active_voices, out_ch.active_voices);
                    errors++;
                end
                if (out_ch.sound_playing !== e.sound_playing)
                begin
                    $error("sound_playing expected %0d actual %0d",
                           e.sound_playing, out_ch.sound_playing);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        int k;
        send_op(psp_pkg::OP_FRAME, 3'd0, 14'd0, 16'sd0, 1'b0, 16'd0, 24'd0, 15'd0);
        // A trigger on a sound that was never loaded does nothing.
        send_op(psp_pkg::OP_TRIG, 3'd2, 14'd0, 16'sd0, 1'b0, 16'hFFFF, 24'h010000, 15'd0);
        send_op(psp_pkg::OP_LOAD, 3'd0, 14'd0, 16'sh7FFF, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_LOAD, 3'd0, 14'd1, -16'sh8000, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_LOAD, 3'd0, 14'd2, 16'sh1234, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_LOAD, 3'd0, 14'd3, -16'sd1, 1'b1, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_LOAD, 3'd1, 14'd0, -16'sh8000, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_LOAD, 3'd1, 14'd1, 16'sh7FFF, 1'b1, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_LOAD, 3'd7, 14'h3FFF, 16'sh5A5A, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_TRIG, 3'd0, 14'd0, 16'sd0, 1'b0, 16'hFFFF, 24'h010000, 15'd0);
        send_op(psp_pkg::OP_TRIG, 3'd1, 14'd0, 16'sd0, 1'b0, 16'd0, 24'hFFFFFF, 15'h7FFF);
        send_op(psp_pkg::OP_TRIG, 3'd0, 14'd0, 16'sd0, 1'b0, 16'd4096, 24'd0, 15'd3);
        for (k = 0; k < 3; k++)
            send_op(psp_pkg::OP_FRAME, 3'd0, 14'd0, 16'sd0, 1'b0, 16'd0, 24'd0, 15'd0);
        for (k = 0; k < 6; k++)
            send_op(psp_pkg::OP_TRIG, 3'd1, 14'd0, 16'sd0, 1'b0, 16'(100 + k), 24'h008000,
                    15'd2);
        send_op(psp_pkg::OP_TRIG, 3'd0, 14'd0, 16'sd0, 1'b0, 16'd50, 24'h018000, 15'd4);
        send_op(psp_pkg::OP_LOOP, 3'd0, 14'd0, 16'sd0, 1'b0, 16'd0, 24'd0, 15'd1);
        send_op(psp_pkg::OP_LOOP, 3'd1, 14'd0, 16'sd0, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_FRAME, 3'd1, 14'd0, 16'sd0, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_STOP, 3'd1, 14'd0, 16'sd0, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(OP_SPARE6, 3'd0, 14'h3FFF, -16'sd1, 1'b1, 16'hFFFF, 24'hFFFFFF, 15'h7FFF);
        send_op(OP_SPARE7, 3'd0, 14'd0, 16'sd0, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_ALL, 3'd0, 14'd0, 16'sd0, 1'b0, 16'd0, 24'd0, 15'd0);
        send_op(psp_pkg::OP_FRAME, 3'd0, 14'd0, 16'sd0, 1'b0, 16'd0, 24'd0, 15'd0);
    endtask

    // Mostly loads that grow each sound's written prefix, triggers and frames.
    task automatic test_random(int count);
        cmd_t c;
        int r;
        int p;
        int k;
        for (k = 0; k < count; k++)
        begin
            c.opcode = psp_pkg::OP_FRAME;
            c.sound_id = 3'($urandom_range(psp_pkg::SOUNDS - 1));
            c.word_index = 14'($urandom);
            c.sample_value = 16'($urandom);
            c.last_word = 1'b0;
            c.gain = 16'($urandom);
            c.pitch_ratio = 24'($urandom);
            c.loop_end = 15'($urandom);
            r = $urandom_range(99);
            if (r < 18)
            begin
                c.opcode = psp_pkg::OP_LOAD;
                p = snd_prefix[c.sound_id];
                if ($urandom_range(9) != 0)
                begin
                    c.word_index = 14'($urandom_range(0, (p < 48) ? p : 47));
                    c.last_word = ($urandom_range(2) == 0);
                end
            end
            else if (r < 38)
            begin
                c.opcode = psp_pkg::OP_TRIG;
                if ($urandom_range(1) == 0)
                    c.gain = 16'($urandom_range(0, 8192));
                if ($urandom_range(4) != 0)
                    c.pitch_ratio = 24'($urandom_range(24'h002000, 24'h030000));
                case ($urandom_range(4))
                    0, 1: c.loop_end = '0;
                    2, 3: c.loop_end = 15'($urandom_range(1, 48));
                    default: ;
                endcase
            end
            else if (r < 45)
            begin
                c.opcode = psp_pkg::OP_LOOP;
                if ($urandom_range(1) == 0)
                    c.loop_end = 15'($urandom_range(0, 48));
            end
            else if (r < 50)
                c.opcode = psp_pkg::OP_STOP;
            else if (r < 52)
                c.opcode = psp_pkg::OP_ALL;
            else if (r < 55)
                c.opcode = ($urandom_range(1) == 0) ? OP_SPARE6 : OP_SPARE7;
            send_cmd(c);
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.opcode = psp_pkg::OP_LOAD;
        in_ch.sound_id = '0;
        in_ch.word_index = '0;
        in_ch.sample_value = '0;
        in_ch.last_word = 1'b0;
        in_ch.gain = '0;
        in_ch.pitch_ratio = '0;
        in_ch.loop_end = '0;
        out_ch.ready = 1'b0;
        foreach (snd_len[s])
        begin
            snd_len[s] = '0;
            snd_prefix[s] = 0;
        end
        foreach (vc_active[v])
        begin
            vc_active[v] = 1'b0;
            vc_sound[v] = '0;
            vc_pos[v] = '0;
            vc_len[v] = '0;
            vc_loop[v] = '0;
            vc_gain[v] = '0;
            vc_pitch[v] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(NUM_RANDOM / 4);
        src_idle_pct = 84;
        test_random(NUM_RANDOM / 4);
        src_idle_pct = 0;
        sink_stall_pct = 84;
        test_random(NUM_RANDOM / 4);
        src_idle_pct = 31;
        sink_stall_pct = 31;
        test_random(NUM_RANDOM / 4);

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Sent %0d transactions (%0d frames) under four idle/stall mixes;", n_items,
                 n_frames);
        $display("checked %0d result transactions, %0d mismatches.", n_results, errors);
        if (errors == 0)
            $display("PASS polyphonic_sample_player_unit");
        else
            $display("FAIL polyphonic_sample_player_unit");
        $finish;
    end
endmodule
